FILE: rtl/lpd_pkg.sv
package lpd_pkg;

	localparam int PAIRS   = 8;
	localparam int PAIR_W  = $clog2(PAIRS);
	localparam int CNT_W   = $clog2(PAIRS + 1);
	localparam int LOAD_W  = 16;
	localparam int WORK_W  = 2 * PAIRS;
	localparam int NTASK_W = 5;
	localparam int USED_W  = NTASK_W + 1;
	localparam int TASK_W  = 4;
	localparam int TOG_W   = 6;

	localparam logic [TOG_W-1:0] TOG_BASE = TOG_W'(11);
	localparam logic [TOG_W-1:0] TOG_STEP = TOG_W'(3);

	typedef struct packed {
		logic [LOAD_W-1:0]  load_pair0;
		logic [LOAD_W-1:0]  load_pair1;
		logic [LOAD_W-1:0]  load_pair2;
		logic [LOAD_W-1:0]  load_pair3;
		logic [LOAD_W-1:0]  load_pair4;
		logic [LOAD_W-1:0]  load_pair5;
		logic [LOAD_W-1:0]  load_pair6;
		logic [LOAD_W-1:0]  load_pair7;
		logic [WORK_W-1:0]  ready_mask;
		logic [NTASK_W-1:0] task_count;
	} round_t;

	typedef struct packed {
		logic [PAIR_W-1:0] pair_id;
		logic              dispatched;
		logic [TASK_W-1:0] first_task;
		logic              second_valid;
		logic              idle_fill;
		logic [TOG_W-1:0]  toggle_count;
		logic              last;
	} result_t;

	// one slot of the sorting row
	typedef struct packed {
		logic              vld;
		logic [LOAD_W-1:0] key;
		logic [PAIR_W-1:0] id;
		logic              both;
	} elem_t;

	// what the drain chain keeps of a sorted slot
	typedef struct packed {
		logic [PAIR_W-1:0] id;
		logic              both;
	} slot_t;

endpackage

FILE: rtl/lpd_sort_cell.sv
module lpd_sort_cell import lpd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  go,
	input  logic  start,
	input  elem_t new_elem,
	input  elem_t left,
	input  logic  left_ins,
	output elem_t q,
	output logic  ins
);

	elem_t cell_q;
	elem_t shift_elem;
	logic  v_eff;

	// start of a round empties the row in the same beat as the first insert
	assign v_eff = cell_q.vld && !start;
	// strict compare: an equal key already held stays ahead (lower pair first)
	assign ins   = !v_eff || (new_elem.key < cell_q.key);
	assign q     = cell_q;

	always_comb begin
		shift_elem     = left;
		shift_elem.vld = left.vld && !start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (go && ins) begin
			cell_q <= left_ins ? shift_elem : new_elem;
		end
	end

endmodule

FILE: rtl/lpd_drain.sv
module lpd_drain import lpd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  slot_t              slots [PAIRS],
	input  logic [NTASK_W-1:0] ntask,
	output logic               free,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result
);

	slot_t              slot_q [PAIRS];
	logic [CNT_W-1:0]   cnt_q;
	logic [USED_W-1:0]  used_q;
	logic [TOG_W-1:0]   tog_q;
	logic [NTASK_W-1:0] ntask_q;
	logic               out_vld_q;
	result_t            out_q;

	logic               pop;
	logic               remain;
	logic               disp;
	logic [TOG_W-1:0]   tog_nxt;
	logic               is_last;

	assign pop     = (cnt_q != '0) && (!out_vld_q || !result_stall);
	assign free    = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && pop);
	assign remain  = used_q < {1'b0, ntask_q};
	assign disp    = remain && slot_q[0].both;
	assign tog_nxt = disp ? tog_q + TOG_STEP : tog_q;
	assign is_last = cnt_q == CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			used_q    <= '0;
			tog_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q  <= CNT_W'(PAIRS);
				used_q <= '0;
				tog_q  <= TOG_BASE;
			end else if (pop) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				used_q <= disp ? used_q + USED_W'(2) : used_q;
				tog_q  <= tog_nxt;
			end
			if (pop) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q  <= slots;
			ntask_q <= ntask;
		end else if (pop) begin
			for (int i = 0; i < PAIRS - 1; i++) begin
				slot_q[i] <= slot_q[i+1];
			end
		end
		if (pop) begin
			out_q.pair_id      <= slot_q[0].id;
			out_q.dispatched   <= disp;
			out_q.first_task   <= disp ? used_q[TASK_W-1:0] : '0;
			out_q.second_valid <= disp && ((used_q + USED_W'(1)) < {1'b0, ntask_q});
			out_q.idle_fill    <= !remain && slot_q[0].both;
			out_q.toggle_count <= is_last ? tog_nxt : '0;
			out_q.last         <= is_last;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

endmodule

FILE: rtl/least_loaded_pair_task_dispatch.sv
// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------
// round    | round_valid / round_stall  | round_t, one beat per round
// result   | result_valid / result_stall| result_t, eight beats per round
//
// A round is fed into the sorting row one pair per cycle while the row is not
// held full, then handed whole to the drain chain, which issues one result
// per cycle while the result is not stalled. Sorting of one round overlaps the
// draining of the previous one, so the sustained rate is set by the drain.
// arst_n clears all control state; a stalled result holds the drain and,
// once the row is full, the feeding of the next round.
module least_loaded_pair_task_dispatch import lpd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    round_valid,
	output logic    round_stall,
	input  round_t  round,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic [LOAD_W-1:0]  load_q [PAIRS];
	logic [WORK_W-1:0]  ready_q;
	logic [NTASK_W-1:0] ntask_q;
	logic [NTASK_W-1:0] ntask_sort_q;
	logic [PAIR_W-1:0]  feed_cnt_q;
	logic               feeding_q;
	logic               full_q;

	logic  feed_go;
	logic  feed_last;
	logic  accept;
	logic  xfer;
	logic  drain_free;
	logic  start;
	elem_t new_elem;
	elem_t row [PAIRS];
	logic  ins [PAIRS];
	slot_t slots [PAIRS];

	assign xfer        = full_q && drain_free;
	assign feed_go     = feeding_q && (!full_q || xfer);
	assign feed_last   = feed_cnt_q == PAIR_W'(PAIRS - 1);
	assign round_stall = feeding_q && !(feed_go && feed_last);
	assign accept      = round_valid && !round_stall;
	assign start       = feed_go && (feed_cnt_q == '0);

	assign new_elem.vld  = 1'b1;
	assign new_elem.key  = load_q[0];
	assign new_elem.id   = feed_cnt_q;
	assign new_elem.both = ready_q[0] && ready_q[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feeding_q  <= 1'b0;
			feed_cnt_q <= '0;
			full_q     <= 1'b0;
		end else begin
			if (accept) begin
				feeding_q <= 1'b1;
			end else if (feed_go && feed_last) begin
				feeding_q <= 1'b0;
			end
			if (accept) begin
				feed_cnt_q <= '0;
			end else if (feed_go) begin
				feed_cnt_q <= feed_cnt_q + PAIR_W'(1);
			end
			if (feed_go && feed_last) begin
				full_q <= 1'b1;
			end else if (xfer) begin
				full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			load_q[0] <= round.load_pair0;
			load_q[1] <= round.load_pair1;
			load_q[2] <= round.load_pair2;
			load_q[3] <= round.load_pair3;
			load_q[4] <= round.load_pair4;
			load_q[5] <= round.load_pair5;
			load_q[6] <= round.load_pair6;
			load_q[7] <= round.load_pair7;
			ready_q   <= round.ready_mask;
			ntask_q   <= round.task_count;
		end else if (feed_go) begin
			for (int i = 0; i < PAIRS - 1; i++) begin
				load_q[i] <= load_q[i+1];
			end
			ready_q <= ready_q >> 2;
		end
		if (feed_go && feed_last) begin
			ntask_sort_q <= ntask_q;
		end
	end

	for (genvar i = 0; i < PAIRS; i++) begin : g_cell
		if (i == 0) begin : g_head
			lpd_sort_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.go       (feed_go),
				.start    (start),
				.new_elem (new_elem),
				.left     ('0),
				.left_ins (1'b0),
				.q        (row[i]),
				.ins      (ins[i])
			);
		end else begin : g_body
			lpd_sort_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.go       (feed_go),
				.start    (start),
				.new_elem (new_elem),
				.left     (row[i-1]),
				.left_ins (ins[i-1]),
				.q        (row[i]),
				.ins      (ins[i])
			);
		end
		assign slots[i].id   = row[i].id;
		assign slots[i].both = row[i].both;
	end

	lpd_drain u_drain (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (xfer),
		.slots        (slots),
		.ntask        (ntask_sort_q),
		.free         (drain_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

FILE: rtl/lpd_checker.sv
module lpd_checker import lpd_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

	a_tog_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last || result.toggle_count == '0))
		else $error("toggle count on a non-final beat");

	a_tog_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |->
			(result.toggle_count >= TOG_BASE) && (result.toggle_count <= TOG_W'(35)))
		else $error("toggle count out of range");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.dispatched && result.idle_fill))
		else $error("pair both dispatched and idle filled");

	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.dispatched |->
			(result.first_task == '0) && !result.second_valid)
		else $error("task fields set on undispatched pair");

endmodule

bind least_loaded_pair_task_dispatch lpd_checker u_lpd_checker (.*);

FILE: test/least_loaded_pair_task_dispatch_test.sv
`timescale 1ns / 1ps

module least_loaded_pair_task_dispatch_test;
	import lpd_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 24;
	localparam int REPORT_CAP     = 60;

	logic    clk;
	logic    arst_n;
	logic    round_valid;
	logic    round_stall;
	round_t  round;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	result_t dispatch_q[$];

	int errors;
	int rounds_sent;
	int results_checked;
	int held_cycles;
	int quiet_cycles;
	int gap_max;
	int burst_left;
	int stall_pct;
	int stall_run;
	int hold_cycles;

	least_loaded_pair_task_dispatch DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.round_valid  (round_valid),
		.round_stall  (round_stall),
		.round        (round),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= REPORT_CAP)
			$display("%0t: %s got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic round_t build_round(input logic [PAIRS-1:0][LOAD_W-1:0] ld,
			input logic [WORK_W-1:0] mask, input logic [NTASK_W-1:0] count);
		round_t r;
		r.load_pair0 = ld[0];
		r.load_pair1 = ld[1];
		r.load_pair2 = ld[2];
		r.load_pair3 = ld[3];
		r.load_pair4 = ld[4];
		r.load_pair5 = ld[5];
		r.load_pair6 = ld[6];
		r.load_pair7 = ld[7];
		r.ready_mask = mask;
		r.task_count = count;
		return r;
	endfunction

	// loads form a ramp base + step*p, wrapped to the load width
	function automatic round_t ramp_round(input int base, input int step,
			input logic [WORK_W-1:0] mask, input int count);
		logic [PAIRS-1:0][LOAD_W-1:0] ld;
		for (int p = 0; p < PAIRS; p++)
			ld[p] = LOAD_W'(base + step * p);
		return build_round(ld, mask, NTASK_W'(count));
	endfunction

	function automatic round_t random_round();
		logic [PAIRS-1:0][LOAD_W-1:0] ld;
		logic [WORK_W-1:0] mask;
		logic [NTASK_W-1:0] count;
		int style;
		int base;
		style = $urandom_range(3);
		base = $urandom_range(65000);
		for (int p = 0; p < PAIRS; p++) begin
			case (style)
				0: ld[p] = LOAD_W'($urandom);
				1: ld[p] = LOAD_W'($urandom_range(3));
				2: ld[p] = ($urandom_range(1) != 0) ? '1 : '0;
				default: ld[p] = LOAD_W'(base + $urandom_range(500));
			endcase
		end
		if ($urandom_range(4) == 0) begin
			mask = WORK_W'($urandom);
		end else begin
			// mostly whole pairs ready so that tasks actually go out
			for (int p = 0; p < PAIRS; p++)
				mask[2*p +: 2] = ($urandom_range(9) < 7) ? 2'b11 : 2'($urandom);
		end
		if ($urandom_range(6) == 0)
			count = NTASK_W'($urandom_range(17, 31));
		else
			count = NTASK_W'($urandom_range(16));
		return build_round(ld, mask, count);
	endfunction

	// stable ascending order of pair loads, then the visit of that order
	function automatic void predict_dispatch(input round_t r);
		logic [PAIRS-1:0][LOAD_W-1:0] ld;
		int order [PAIRS];
		int cur;
		int j;
		int used;
		int ntask;
		bit both;
		logic [TOG_W-1:0] toggles;
		result_t res;
		ld = {r.load_pair7, r.load_pair6, r.load_pair5, r.load_pair4,
			r.load_pair3, r.load_pair2, r.load_pair1, r.load_pair0};
		for (int i = 0; i < PAIRS; i++)
			order[i] = i;
		for (int i = 1; i < PAIRS; i++) begin
			cur = order[i];
			j = i;
			while (j > 0 && ld[order[j-1]] > ld[cur]) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = cur;
		end
		used = 0;
		ntask = r.task_count;
		toggles = TOG_BASE;
		for (int k = 0; k < PAIRS; k++) begin
			both = r.ready_mask[2*order[k]] && r.ready_mask[2*order[k] + 1];
			res = '0;
			res.pair_id = PAIR_W'(order[k]);
			if (used < ntask) begin
				if (both) begin
					res.dispatched = 1'b1;
					res.first_task = TASK_W'(used);
					res.second_valid = (used + 1 < ntask);
					used += 2;
					toggles += TOG_STEP;
				end
			end else if (both) begin
				res.idle_fill = 1'b1;
			end
			if (k == PAIRS - 1) begin
				res.toggle_count = toggles;
				res.last = 1'b1;
			end
			dispatch_q.insert(dispatch_q.size(), res);
		end
	endfunction

	// called at a falling edge; returns at a falling edge
	task automatic send_round(input round_t r);
		int gap;
		round_valid <= 1'b1;
		round <= r;
		@(posedge clk);
		while (round_stall)
			@(posedge clk);
		predict_dispatch(r);
		rounds_sent++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(gap_max);
			burst_left = $urandom_range(1, 8);
			if (gap > 0) begin
				round_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// receiver: runs of stall or no stall, plus an optional long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			result_stall <= 1'b1;
		end else if (stall_run > 0) begin
			stall_run--;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
			stall_run = $urandom_range(5);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (dispatch_q.size() == 0) begin
				report_mismatch("unexpected result beat, pair_id", result.pair_id, -1);
			end else begin
				want = dispatch_q.pop_front();
				results_checked++;
				if (result.pair_id !== want.pair_id)
					report_mismatch("pair_id", result.pair_id, want.pair_id);
				if (result.dispatched !== want.dispatched)
					report_mismatch("dispatched", result.dispatched, want.dispatched);
				if (result.first_task !== want.first_task)
					report_mismatch("first_task", result.first_task, want.first_task);
				if (result.second_valid !== want.second_valid)
					report_mismatch("second_valid", result.second_valid, want.second_valid);
				if (result.idle_fill !== want.idle_fill)
					report_mismatch("idle_fill", result.idle_fill, want.idle_fill);
				if (result.toggle_count !== want.toggle_count)
					report_mismatch("toggle_count", result.toggle_count, want.toggle_count);
				if (result.last !== want.last)
					report_mismatch("last", result.last, want.last);
			end
		end
	end

	always @(posedge clk) begin
		if (round_valid && round_stall)
			held_cycles++;
		if ((round_valid && !round_stall) || (arst_n && result_valid && !result_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles, %0d results outstanding",
					$time, quiet_cycles, dispatch_q.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic test_directed_rounds();
		round_t r;
		gap_max = 4;
		stall_pct = 25;
		send_round(ramp_round(0, 0, 16'hFFFF, 0));           // all tied, all idle fill
		send_round(ramp_round(65535, 0, 16'hFFFF, 16));      // all loads at maximum
		send_round(ramp_round(7000, -1000, 16'hFFFF, 16));   // reverse order
		send_round(ramp_round(0, 1000, 16'hFFFF, 7));        // odd count
		send_round(ramp_round(0, 0, 16'h0000, 16));          // nobody ready
		send_round(ramp_round(100, 0, 16'h5555, 8));         // only even workers
		send_round(ramp_round(100, 0, 16'hAAAA, 8));         // only odd workers
		send_round(ramp_round(0, 1, 16'hFFFF, 31));          // surplus tasks
		send_round(ramp_round(0, 1, 16'hFFFF, 17));
		send_round(ramp_round(0, 1, 16'hF0F0, 4));
		send_round(ramp_round(0, 0, 16'h3C3C, 1));
		send_round(ramp_round(0, 0, 16'hFFFF, 15));
		send_round(ramp_round(0, 0, 16'hFFFF, 3));
		send_round(ramp_round(0, 0, 16'hFFFE, 2));           // first pair skipped, not ready
		send_round(ramp_round(0, 9362, 16'h9669, 9));
		send_round(ramp_round(65535, -1, 16'hFFFF, 5));
		r = ramp_round(65535, 0, 16'hFFFF, 5);
		r.load_pair1 = 16'h8000;
		r.load_pair3 = 16'h0000;
		r.load_pair5 = 16'h0000;
		send_round(r);
		send_round(ramp_round(2, 0, 16'hCF3F, 11));
	endtask

	task automatic test_random_rounds();
		gap_max = 12;
		stall_pct = 30;
		repeat (300) send_round(random_round());
	endtask

	task automatic test_back_to_back();
		gap_max = 0;
		stall_pct = 0;
		repeat (60) send_round(random_round());
	endtask

	// receiver holds off while rounds keep coming, so the input side backs up
	task automatic test_output_hold_off();
		gap_max = 0;
		stall_pct = 20;
		hold_cycles = 300;
		repeat (20) send_round(random_round());
	endtask

	task automatic test_heavy_stall();
		gap_max = 3;
		stall_pct = 75;
		repeat (60) send_round(random_round());
	endtask

	initial begin
		arst_n = 1'b0;
		round_valid = 1'b0;
		round = '0;
		result_stall = 1'b0;
		errors = 0;
		rounds_sent = 0;
		results_checked = 0;
		held_cycles = 0;
		quiet_cycles = 0;
		gap_max = 0;
		burst_left = 0;
		stall_pct = 0;
		stall_run = 0;
		hold_cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_rounds();
		test_random_rounds();
		test_back_to_back();
		test_output_hold_off();
		test_heavy_stall();
		round_valid <= 1'b0;

		wait (dispatch_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d dispatch rounds and checked %0d pair results.",
			rounds_sent, results_checked);
		$display("Input was held back on %0d cycles; %0d mismatches.", held_cycles, errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
rtl/lpd_pkg.sv
rtl/lpd_sort_cell.sv
rtl/lpd_drain.sv
rtl/least_loaded_pair_task_dispatch.sv
rtl/lpd_checker.sv
test/least_loaded_pair_task_dispatch_test.sv
